[sv/dstwr_pkg.sv]
// Package for the double-sided two-way ranging distance pipeline.
// Holds the fixed scale constant and result widths; no dependencies.
`default_nettype none
package dstwr_pkg;
  localparam int unsigned RangeBits = 32;
  localparam int unsigned ScaleBits = 19;
  localparam int unsigned ScaleShift = 16;
  // round(4.6903573 * 2^16): millimetres per device tick, Q16
  localparam logic [ScaleBits-1:0] MmPerTickQ16 = 19'd307387;
endpackage
`default_nettype wire

[sv/ds_twr_distance_calc.sv]
// Top level of the double-sided two-way ranging distance pipeline.
// Depends on dstwr_pkg and dstwr_div.
//
// Usage: drive the six timestamps and pulse start; busy is always low, so a
// request is taken every cycle start is high. Each request gives exactly one
// result: done is high for one cycle with range_mm and range_ok.
// Stages: 1 differences, 2 sum and 40x40 split products, 3-4 product sums,
// 5 numerator and compare, then 2*STAMP_BITS divider stages (one quotient
// bit each), then scale multiply and saturate. Throughput is one request
// per cycle, set by the bit-per-stage divider pipeline. Reset clears all
// valid bits; results in flight are dropped. The receiver cannot stall, so
// nothing ever waits.
// range_ok is low and range_mm zero when the sum of times is zero or the
// time of flight is not positive; distances past 2^32-1 mm saturate.
`default_nettype none
module ds_twr_distance_calc #(
  parameter int unsigned STAMP_BITS = 40
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [STAMP_BITS-1:0] poll_sent,
  input  wire logic [STAMP_BITS-1:0] poll_seen,
  input  wire logic [STAMP_BITS-1:0] reply_sent,
  input  wire logic [STAMP_BITS-1:0] reply_seen,
  input  wire logic [STAMP_BITS-1:0] last_sent,
  input  wire logic [STAMP_BITS-1:0] last_seen,
  output logic                       done,
  output logic [dstwr_pkg::RangeBits-1:0] range_mm,
  output logic                       range_ok
);
  localparam int unsigned SB   = STAMP_BITS;
  localparam int unsigned HB   = (SB + 1) / 2;
  localparam int unsigned LB   = SB - HB;
  localparam int unsigned PB   = 2 * SB;
  localparam int unsigned NB   = PB;
  localparam int unsigned DB   = SB + 2;
  localparam int unsigned RB   = dstwr_pkg::RangeBits;
  localparam int unsigned MB   = RB + dstwr_pkg::ScaleBits;

  assign busy = 1'b0;

  // stage 1: differences mod 2^SB
  logic          v1;
  logic [SB-1:0] ra1, rb1, pa1, pb1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    ra1 <= reply_seen - poll_sent;
    rb1 <= last_seen - reply_sent;
    pa1 <= last_sent - reply_seen;
    pb1 <= reply_sent - poll_seen;
  end

  // stage 2: denominator and split partial products (each <= ~20x20 bits)
  logic          v2;
  logic [DB-1:0] den2;
  logic [2*HB-1:0] a_hh, b_hh;
  logic [HB+LB-1:0] a_hl, a_lh, b_hl, b_lh;
  logic [2*LB-1:0] a_ll, b_ll;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    den2 <= DB'(ra1) + DB'(rb1) + DB'(pa1) + DB'(pb1);
    a_hh <= ra1[SB-1:LB] * rb1[SB-1:LB];
    a_hl <= ra1[SB-1:LB] * rb1[LB-1:0];
    a_lh <= ra1[LB-1:0] * rb1[SB-1:LB];
    a_ll <= ra1[LB-1:0] * rb1[LB-1:0];
    b_hh <= pa1[SB-1:LB] * pb1[SB-1:LB];
    b_hl <= pa1[SB-1:LB] * pb1[LB-1:0];
    b_lh <= pa1[LB-1:0] * pb1[SB-1:LB];
    b_ll <= pa1[LB-1:0] * pb1[LB-1:0];
  end

  // stage 3: combine cross terms
  logic          v3;
  logic [DB-1:0] den3;
  logic [PB-1:0] a_out3, b_out3;
  logic [HB+LB:0] a_mid3, b_mid3;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    den3   <= den2;
    a_out3 <= {a_hh, a_ll};
    b_out3 <= {b_hh, b_ll};
    a_mid3 <= (HB+LB+1)'(a_hl) + (HB+LB+1)'(a_lh);
    b_mid3 <= (HB+LB+1)'(b_hl) + (HB+LB+1)'(b_lh);
  end

  // stage 4: full products
  logic          v4;
  logic [DB-1:0] den4;
  logic [PB-1:0] pos4, neg4;
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    den4 <= den3;
    pos4 <= a_out3 + (PB'(a_mid3) << LB);
    neg4 <= b_out3 + (PB'(b_mid3) << LB);
  end

  // stage 5: numerator and validity
  logic          v5, ok5;
  logic [DB-1:0] den5;
  logic [NB-1:0] num5;
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    den5 <= (den4 == '0) ? DB'(1) : den4;
    ok5  <= (den4 != '0) && (pos4 > neg4);
    num5 <= pos4 - neg4;
  end

  logic          vd, okd;
  logic [NB-1:0] tof;
  dstwr_div #(.NUM_BITS(NB), .DEN_BITS(DB)) u_div (
    .clk(clk), .rst(rst), .in_valid(v5), .in_flag(ok5),
    .num(num5), .den(den5), .out_valid(vd), .out_flag(okd), .quo(tof)
  );

  // scale stage: multiply tof by Q16 constant
  logic          v6, ok6, big6;
  logic [MB-1:0] prod6;
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= vd;
    end
    ok6   <= okd && (tof != '0);
    big6  <= tof[NB-1:RB] != '0;
    prod6 <= tof[RB-1:0] * dstwr_pkg::MmPerTickQ16;
  end

  // output: shift, saturate
  logic [MB-dstwr_pkg::ScaleShift-1:0] mm6;
  assign mm6 = prod6[MB-1:dstwr_pkg::ScaleShift];
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v6;
    end
    range_ok <= ok6;
    if (!ok6) begin
      range_mm <= '0;
    end else if (big6 || mm6[MB-dstwr_pkg::ScaleShift-1:RB] != '0) begin
      range_mm <= '1;
    end else begin
      range_mm <= mm6[RB-1:0];
    end
  end

`ifndef SYNTH
  a_busy_low: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_ok_zero: assert property (@(posedge clk) disable iff (rst)
    done && !range_ok |-> range_mm == '0)
    else $error("invalid range not zero");
  a_zero_den: assert property (@(posedge clk) disable iff (rst)
    v4 && den4 == '0 |=> !ok5)
    else $error("zero denominator marked valid");
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    v6 |=> done)
    else $error("result lost at output");
`endif
endmodule
`default_nettype wire

[sv/dstwr_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Uses dstwr_pkg for nothing; carries a side payload (valid, flag).
`default_nettype none
module dstwr_div #(
  parameter int unsigned NUM_BITS = 82,
  parameter int unsigned DEN_BITS = 43
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_flag,
  input  wire logic [NUM_BITS-1:0] num,
  input  wire logic [DEN_BITS-1:0] den,
  output logic                     out_valid,
  output logic                     out_flag,
  output logic [NUM_BITS-1:0]      quo
);
  logic [NUM_BITS:0]   vld;
  logic [NUM_BITS:0]   flg;
  logic [NUM_BITS-1:0] qn  [NUM_BITS+1];
  logic [DEN_BITS-1:0] rem [NUM_BITS+1];
  logic [DEN_BITS-1:0] dv  [NUM_BITS+1];

  assign vld[0] = in_valid;
  assign flg[0] = in_flag;
  assign qn[0]  = num;
  assign rem[0] = '0;
  assign dv[0]  = den;

  for (genvar s = 0; s < NUM_BITS; s++) begin : g_stage
    logic [DEN_BITS:0] trial;
    logic              take;
    assign trial = {rem[s], qn[s][NUM_BITS-1]};
    assign take  = trial >= {1'b0, dv[s]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      flg[s+1] <= flg[s];
      dv[s+1]  <= dv[s];
      qn[s+1]  <= {qn[s][NUM_BITS-2:0], take};
      rem[s+1] <= take ? DEN_BITS'(trial - {1'b0, dv[s]}) : trial[DEN_BITS-1:0];
    end
  end

  assign out_valid = vld[NUM_BITS];
  assign out_flag  = flg[NUM_BITS];
  assign quo       = qn[NUM_BITS];
endmodule
`default_nettype wire
